@@ sv/prrs_pkg.sv @@
// Shared codes and default sizes for the priority round-robin task scheduler.
package prrs_pkg;

  localparam int MAX_TASKS_DEF     = 8;
  localparam int PRIORITY_BITS_DEF = 8;
  localparam int SLEEP_BITS_DEF    = 16;
  localparam int SP_W              = 64;

  // operation codes
  typedef enum logic [2:0] {
    FN_CREATE   = 3'd0,
    FN_SWITCH   = 3'd1,
    FN_TICK     = 3'd2,
    FN_SET_ST   = 3'd3,
    FN_SET_PRIO = 3'd4,
    FN_RESTORE  = 3'd5,
    FN_SLEEP    = 3'd6,
    FN_QUERY    = 3'd7
  } func_t;

  // task states
  typedef enum logic [1:0] {
    TS_READY    = 2'd0,
    TS_RUNNING  = 2'd1,
    TS_SLEEPING = 2'd2,
    TS_BLOCKED  = 2'd3
  } tstate_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_ID  = 2'd2,
    STAT_NO_TASK = 2'd3
  } status_t;

endpackage

@@ sv/priority_round_robin_task_scheduler.sv @@
// Top level of the priority round-robin task scheduler: task table memory and sequencer.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------------------
//  in      | in_valid  | in_stall  | func task_id stack_pointer priority_req new_state
//          |           |           | sleep_len
//  out     | out_valid | out_stall | status task_id_out stack_pointer_out priority_out
//          |           |           | running_id
//
// Create and error answers use the dispatch and done states; set state, set priority,
// restore and query also use the modify state. Tick adds a wake-up pass over the N created
// tasks (none if the table is empty), switch or sleep a save and a scan: the task table has
// one read port, so the wake-up pass and the switch scan read one entry a cycle. Reset clears
// the task count, the running index and the sequencer; table contents are only read once
// written. A waiting result stalls only the completion of the following transaction.
module priority_round_robin_task_scheduler #(
  parameter int MAX_TASKS     = prrs_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_BITS = prrs_pkg::PRIORITY_BITS_DEF,
  parameter int SLEEP_BITS    = prrs_pkg::SLEEP_BITS_DEF,
  localparam int IW           = $clog2(MAX_TASKS),
  localparam int CW           = $clog2(MAX_TASKS + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 func,
  input  logic [IW-1:0]              task_id,
  input  logic [prrs_pkg::SP_W-1:0]  stack_pointer,
  input  logic [PRIORITY_BITS-1:0]   priority_req,
  input  logic [1:0]                 new_state,
  input  logic [SLEEP_BITS-1:0]      sleep_len,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [IW-1:0]              task_id_out,
  output logic [prrs_pkg::SP_W-1:0]  stack_pointer_out,
  output logic [PRIORITY_BITS-1:0]   priority_out,
  output logic [IW-1:0]              running_id
);

  typedef struct packed {
    prrs_pkg::tstate_t          st;
    logic [PRIORITY_BITS-1:0]   prio;
    logic [PRIORITY_BITS-1:0]   base;
    logic [SLEEP_BITS-1:0]      slp;
    logic [prrs_pkg::SP_W-1:0]  sp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MOD, S_SWMOD, S_SCAN, S_TICK, S_FIN, S_DONE
  } seq_t;

  seq_t                       seq;
  // latched transaction
  prrs_pkg::func_t            func_r;
  logic [IW-1:0]              id_r;
  logic [prrs_pkg::SP_W-1:0]  sp_r;
  logic [PRIORITY_BITS-1:0]   prio_r;
  prrs_pkg::tstate_t          nst_r;
  logic [SLEEP_BITS-1:0]      ticks_r;
  // scheduler state
  logic [CW-1:0]              count;
  logic [IW-1:0]              cur;
  // pass control
  logic [IW-1:0]              ptr;
  logic [CW-1:0]              issued;
  logic                       pend;
  logic [IW-1:0]              pend_idx;
  logic                       found;
  logic [IW-1:0]              best;
  entry_t                     best_ent;
  // pending result
  prrs_pkg::status_t          res_status;
  logic [IW-1:0]              res_id;
  logic                       res_id_new;
  logic [prrs_pkg::SP_W-1:0]  res_sp;
  logic [PRIORITY_BITS-1:0]   res_prio;

  // task table
  entry_t                     mem [MAX_TASKS];
  entry_t                     rd_data;
  logic                       mem_re;
  logic [IW-1:0]              mem_ra;
  logic                       mem_we;
  logic [IW-1:0]              mem_wa;
  entry_t                     mem_wd;

  logic                       id_ok;
  logic [IW-1:0]              ptr_next;
  logic                       scan_take;
  entry_t                     tick_ent;
  entry_t                     sw_ent;
  logic [SLEEP_BITS-1:0]      slp_dec;

  assign in_stall = (seq != S_IDLE);
  assign id_ok    = (CW'(id_r) < count);
  assign ptr_next = (CW'(ptr) == count - CW'(1)) ? '0 : ptr + IW'(1);

  // scan candidate: ready and strictly more urgent, or first ready seen
  assign scan_take = pend && (rd_data.st == prrs_pkg::TS_READY) &&
                     (!found || (rd_data.prio < best_ent.prio));

  // one tick applied to a returned entry
  always_comb begin
    tick_ent = rd_data;
    slp_dec  = (rd_data.slp != '0) ? rd_data.slp - SLEEP_BITS'(1) : '0;
    if (rd_data.st == prrs_pkg::TS_SLEEPING) begin
      tick_ent.slp = slp_dec;
      if (slp_dec == '0) tick_ent.st = prrs_pkg::TS_READY;
    end
  end

  // running task saved and demoted (or put to sleep)
  always_comb begin
    sw_ent    = rd_data;
    sw_ent.sp = sp_r;
    if (func_r == prrs_pkg::FN_SLEEP) begin
      sw_ent.st  = prrs_pkg::TS_SLEEPING;
      sw_ent.slp = ticks_r;
    end else if (rd_data.st == prrs_pkg::TS_RUNNING) begin
      sw_ent.st = prrs_pkg::TS_READY;
    end
  end

  // table port controls
  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rd_data;
    case (seq)
      S_DISP: begin
        case (func_r)
          prrs_pkg::FN_CREATE: begin
            mem_we      = (count != CW'(MAX_TASKS));
            mem_wa      = count[IW-1:0];
            mem_wd.st   = prrs_pkg::TS_READY;
            mem_wd.prio = prio_r;
            mem_wd.base = prio_r;
            mem_wd.slp  = '0;
            mem_wd.sp   = sp_r;
          end
          prrs_pkg::FN_SWITCH, prrs_pkg::FN_SLEEP: begin
            mem_re = (count != '0);
            mem_ra = cur;
          end
          prrs_pkg::FN_TICK: begin
            mem_re = (count != '0);
            mem_ra = '0;
          end
          default: begin
            mem_re = id_ok;
            mem_ra = id_r;
          end
        endcase
      end
      S_MOD: begin
        mem_we = (func_r != prrs_pkg::FN_QUERY);
        mem_wa = id_r;
        case (func_r)
          prrs_pkg::FN_SET_ST:   mem_wd.st   = nst_r;
          prrs_pkg::FN_SET_PRIO: mem_wd.prio = prio_r;
          prrs_pkg::FN_RESTORE:  mem_wd.prio = rd_data.base;
          default:               mem_wd      = rd_data;
        endcase
      end
      S_SWMOD: begin
        mem_we = 1'b1;
        mem_wa = cur;
        mem_wd = sw_ent;
      end
      S_SCAN: begin
        mem_re = (issued != count);
        mem_ra = ptr;
      end
      S_TICK: begin
        mem_re = (issued != count);
        mem_ra = ptr;
        mem_we = pend;
        mem_wa = pend_idx;
        mem_wd = tick_ent;
      end
      S_FIN: begin
        mem_we    = 1'b1;
        mem_wa    = best;
        mem_wd    = best_ent;
        mem_wd.st = prrs_pkg::TS_RUNNING;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // synchronous table, one read and one write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= S_IDLE;
      count     <= '0;
      cur       <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (seq != S_DONE)) out_valid <= 1'b0;
      case (seq)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= prrs_pkg::func_t'(func);
            id_r    <= task_id;
            sp_r    <= stack_pointer;
            prio_r  <= priority_req;
            nst_r   <= prrs_pkg::tstate_t'(new_state);
            ticks_r <= sleep_len;
            seq     <= S_DISP;
          end
        end
        S_DISP: begin
          res_sp <= '0;
          res_id <= count[IW-1:0];
          case (func_r)
            prrs_pkg::FN_CREATE: begin
              res_prio <= '0;
              seq      <= S_DONE;
              if (count == CW'(MAX_TASKS)) begin
                res_status <= prrs_pkg::STAT_FULL;
                res_id_new <= 1'b0;
              end else begin
                res_status <= prrs_pkg::STAT_OK;
                count      <= count + CW'(1);
                res_id_new <= 1'b1;
              end
            end
            prrs_pkg::FN_SWITCH, prrs_pkg::FN_SLEEP: begin
              res_prio   <= '0;
              res_id_new <= 1'b0;
              if (count == '0) begin
                res_status <= prrs_pkg::STAT_NO_TASK;
                seq        <= S_DONE;
              end else begin
                res_status <= prrs_pkg::STAT_OK;
                seq        <= S_SWMOD;
              end
            end
            prrs_pkg::FN_TICK: begin
              res_prio   <= '0;
              res_id_new <= 1'b0;
              res_status <= prrs_pkg::STAT_OK;
              if (count != '0) begin
                ptr      <= (count == CW'(1)) ? '0 : IW'(1);
                issued   <= CW'(1);
                pend     <= 1'b1;
                pend_idx <= '0;
                seq      <= S_TICK;
              end else begin
                seq <= S_DONE;
              end
            end
            default: begin
              res_id_new <= 1'b0;
              if (id_ok) begin
                res_status <= prrs_pkg::STAT_OK;
                res_prio   <= '0;
                seq        <= S_MOD;
              end else begin
                res_status <= prrs_pkg::STAT_BAD_ID;
                res_prio   <= (func_r == prrs_pkg::FN_QUERY) ? '1 : '0;
                seq        <= S_DONE;
              end
            end
          endcase
        end
        S_MOD: begin
          if (func_r == prrs_pkg::FN_QUERY) res_prio <= rd_data.prio;
          seq <= S_DONE;
        end
        S_SWMOD: begin
          best_ent <= sw_ent;
          best     <= cur;
          found    <= 1'b0;
          ptr      <= (CW'(cur) == count - CW'(1)) ? '0 : cur + IW'(1);
          issued   <= '0;
          pend     <= 1'b0;
          seq      <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_take) begin
            best_ent <= rd_data;
            best     <= pend_idx;
            found    <= 1'b1;
          end
          pend     <= mem_re;
          pend_idx <= ptr;
          if (mem_re) begin
            ptr    <= ptr_next;
            issued <= issued + CW'(1);
          end else if (!pend) begin
            seq <= S_FIN;
          end
        end
        S_TICK: begin
          pend     <= mem_re;
          pend_idx <= ptr;
          if (mem_re) begin
            ptr    <= ptr_next;
            issued <= issued + CW'(1);
          end else if (!pend) begin
            seq <= S_DONE;
          end
        end
        S_FIN: begin
          cur    <= best;
          res_sp <= best_ent.sp;
          seq    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            status            <= res_status;
            task_id_out       <= res_id_new ? res_id : cur;
            stack_pointer_out <= res_sp;
            priority_out      <= res_prio;
            running_id        <= cur;
            seq               <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

endmodule
